@@ sv/assert_macros.svh @@
// Assertion macros for the track pose block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DSTP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dstp assertion failed");
`define DSTP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("dstp assertion failed");
`else
`define DSTP_ASSERT(lbl, prop)
`define DSTP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ sv/dstp_pkg.sv @@
// Types and constants shared by the track pose modules.
`default_nettype none
package dstp_pkg;
  localparam int unsigned OFS_W = 16;
  localparam int unsigned MAG_W = 17;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned ANG_W = 16;
  localparam int unsigned LAT_W = 19;
  localparam logic [LEN_W-1:0] LEN_RESET = 16'd1000;
  localparam logic [1:0] CNT_TWO = 2'd2;

  // CORDIC: operands scaled by 2^20, angle in Q16 radians
  localparam int unsigned CORDIC_FRAC = 20;
  localparam int unsigned CX_W = 40;
  localparam int unsigned CZ_W = 20;
  localparam int unsigned ATAN_N = 24;
  localparam logic [16:0] ATAN_Q16 [ATAN_N] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
    17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2,
    17'd1, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
  };

  // lateral magnitude: root of (L*L+Y*Y)*2^16, then divide
  localparam int unsigned SS_W = 33;
  localparam int unsigned PROD_W = 33;
  localparam int unsigned SQ_W = 50;
  localparam int unsigned ROOT_W = 25;
  localparam int unsigned ROOT_STEPS = 25;
  localparam int unsigned NUM_W = 44;
  localparam int unsigned QUO_STEPS = 19;
  localparam int unsigned MAG_LAT = 1 + ROOT_STEPS + 1 + QUO_STEPS;

  typedef struct packed {
    logic nz;
    logic neg;
  } sgn_t;

  typedef struct packed {
    logic             pose;
    sgn_t             sa;
    sgn_t             sd;
    logic             spec;
    logic [LAT_W-1:0] spec_lat;
  } side_t;
endpackage
`default_nettype wire

@@ sv/dstp_decode.sv @@
// Offset selection and geometric case decode, two register stages.
`default_nettype none
module dstp_decode import dstp_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [1:0]       front_count_i,
  input  logic [OFS_W-1:0] front_offset_a_i,
  input  logic [OFS_W-1:0] front_offset_b_i,
  input  logic [1:0]       rear_count_i,
  input  logic [OFS_W-1:0] rear_offset_a_i,
  input  logic [OFS_W-1:0] rear_offset_b_i,
  output logic [MAG_W-1:0] y_o,
  output logic [MAG_W-1:0] m_o,
  output side_t            side_o
);
  function automatic logic [MAG_W-1:0] mag17(logic [OFS_W-1:0] v);
    return v[OFS_W-1] ? (MAG_W'(0) - {1'b1, v}) : {1'b0, v};
  endfunction

  function automatic logic [OFS_W-1:0] pick(logic [1:0] c, logic [OFS_W-1:0] a,
                                            logic [OFS_W-1:0] b);
    logic [OFS_W-1:0] r;
    r = a;
    if (c == CNT_TWO && !(mag17(a) < mag17(b))) r = b;
    return r;
  endfunction

  logic [OFS_W-1:0] o1_q, o2_q;
  logic             pv_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o1_q <= pick(front_count_i, front_offset_a_i, front_offset_b_i);
      o2_q <= pick(rear_count_i, rear_offset_a_i, rear_offset_b_i);
      pv_q <= (front_count_i != 2'd0) && (rear_count_i != 2'd0);
    end
  end

  logic [MAG_W-1:0] a1, a2, dmag, dfm, y_d, m_d;
  logic [MAG_W:0]   d;
  logic [MAG_W-1:0] diff;
  logic             n1, n2, z1, z2;
  side_t            side_d;

  always_comb begin
    a1   = mag17(o1_q);
    a2   = mag17(o2_q);
    n1   = o1_q[OFS_W-1];
    n2   = o2_q[OFS_W-1];
    z1   = (o1_q == '0);
    z2   = (o2_q == '0);
    d    = {1'b0, a2} - {1'b0, a1};
    dmag = d[MAG_W] ? MAG_W'((MAG_W+1)'(0) - d) : d[MAG_W-1:0];
    diff = {n1, o1_q} - {n2, o2_q};
    dfm  = diff[MAG_W-1] ? (MAG_W'(0) - diff) : diff;
    y_d  = '0;
    m_d  = '0;
    side_d = '0;
    side_d.pose = pv_q;
    if (pv_q) begin
      if (z1 && z2) begin
        y_d = '0;
      end else if (z1) begin
        y_d = a2;
        m_d = a2;
        side_d.sa = '{nz: 1'b1, neg: ~n2};
        side_d.sd = '{nz: 1'b1, neg: n2};
      end else if (z2) begin
        y_d = a1;
        m_d = a1;
        side_d.sa = '{nz: 1'b1, neg: ~n1};
        side_d.sd = '{nz: 1'b1, neg: ~n1};
      end else if (n1 != n2) begin
        if (a1 == a2) begin
          side_d.spec     = 1'b1;
          side_d.spec_lat = LAT_W'(0) - {n1, o1_q, 2'b00};
        end else begin
          y_d = dmag;
          m_d = a1 + a2;
          if (!n1) begin
            side_d.sa = '{nz: 1'b1, neg: d[MAG_W]};
            side_d.sd = '{nz: 1'b1, neg: 1'b1};
          end else begin
            side_d.sa = '{nz: 1'b1, neg: ~d[MAG_W]};
            side_d.sd = '{nz: 1'b1, neg: 1'b0};
          end
        end
      end else begin
        y_d = a1 + a2;
        m_d = dfm;
        side_d.sa = '{nz: 1'b1, neg: ~n1};
        side_d.sd = '{nz: 1'b1, neg: (a2 > a1) ? n1 : ~n1};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_o    <= y_d;
      m_o    <= m_d;
      side_o <= side_d;
    end
  end
endmodule
`default_nettype wire

@@ sv/dstp_cordic.sv @@
// Pipelined vectoring CORDIC arctangent with delay to match the magnitude path.
`default_nettype none
module dstp_cordic import dstp_pkg::*; #(
  parameter int unsigned STAGES = 16,
  parameter int unsigned DEPTH  = 46
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] y_i,
  input  logic [LEN_W-1:0] len_i,
  output logic [ANG_W-1:0] angle_o
);
  localparam int unsigned N   = (STAGES < ATAN_N) ? STAGES : ATAN_N;
  localparam int unsigned PAD = DEPTH - N - 1;
  localparam logic signed [CZ_W-1:0] RND = 4;

  logic signed [CX_W-1:0] x_s [N];
  logic signed [CX_W-1:0] y_s [N];
  logic signed [CZ_W-1:0] z_s [N+1];

  assign x_s[0] = CX_W'({len_i, {CORDIC_FRAC{1'b0}}});
  assign y_s[0] = CX_W'({y_i, {CORDIC_FRAC{1'b0}}});
  assign z_s[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_s[i][CX_W-1]) z_s[i+1] <= z_s[i] + CZ_W'(ATAN_Q16[i]);
        else                 z_s[i+1] <= z_s[i] - CZ_W'(ATAN_Q16[i]);
      end
    end
    if (i < N - 1) begin : g_xy
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!y_s[i][CX_W-1]) begin
            x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
            y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
          end else begin
            x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
            y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
          end
        end
      end
    end
  end

  logic signed [CZ_W-1:0] zr;
  logic [ANG_W-1:0]       dly_q [PAD+1];

  assign zr = z_s[N] + RND;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= ANG_W'(zr >>> 3);
      for (int k = 1; k <= PAD; k++) dly_q[k] <= dly_q[k-1];
    end
  end

  assign angle_o = dly_q[PAD];
endmodule
`default_nettype wire

@@ sv/dstp_mag.sv @@
// Lateral magnitude M*L*512/sqrt((L*L+Y*Y)*2^16), rounded: squares, root, divide.
`default_nettype none
module dstp_mag import dstp_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] y_i,
  input  logic [MAG_W-1:0] m_i,
  input  logic [LEN_W-1:0] len_i,
  output logic [LAT_W-1:0] mag_o
);
  logic [PROD_W-1:0] ml_q;
  logic [SS_W-1:0]   ss_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ml_q <= PROD_W'(m_i) * PROD_W'(len_i);
      ss_q <= SS_W'(len_i) * SS_W'(len_i) + SS_W'(y_i) * SS_W'(y_i);
    end
  end

  // square root, one result bit per stage
  logic [SQ_W-1:0]   v_s   [ROOT_STEPS];
  logic [SQ_W-1:0]   r_s   [ROOT_STEPS+1];
  logic [PROD_W-1:0] num_s [ROOT_STEPS+1];

  assign v_s[0]   = SQ_W'({ss_q, 16'd0});
  assign r_s[0]   = '0;
  assign num_s[0] = ml_q;

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam int unsigned K = ROOT_STEPS - 1 - j;
    localparam logic [SQ_W-1:0] B = SQ_W'(1) << (2 * K);
    logic [SQ_W-1:0] t;
    logic            ge;
    assign t  = r_s[j] + B;
    assign ge = (v_s[j] >= t);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_s[j+1]   <= ge ? ((r_s[j] >> 1) + B) : (r_s[j] >> 1);
        num_s[j+1] <= num_s[j];
      end
    end
    if (j < ROOT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) v_s[j+1] <= ge ? (v_s[j] - t) : v_s[j];
      end
    end
  end

  // restoring divide; root is nonzero whenever the result is used
  logic [ROOT_W-1:0]    root;
  logic [NUM_W-1:0]     rem_s [QUO_STEPS];
  logic [ROOT_W-1:0]    den_s [QUO_STEPS];
  logic [QUO_STEPS-1:0] q_s   [QUO_STEPS+1];

  assign root   = r_s[ROOT_STEPS][ROOT_W-1:0];
  assign q_s[0] = '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_s[0] <= NUM_W'({num_s[ROOT_STEPS], 9'd0}) + NUM_W'(root >> 1);
      den_s[0] <= root;
    end
  end

  for (genvar j = 0; j < QUO_STEPS; j++) begin : g_div
    localparam int unsigned K = QUO_STEPS - 1 - j;
    logic [NUM_W-1:0] dv;
    logic             ge;
    assign dv = NUM_W'(den_s[j]) << K;
    assign ge = (rem_s[j] >= dv);
    always_ff @(posedge clk_i) begin
      if (en_i) q_s[j+1] <= {q_s[j][QUO_STEPS-2:0], ge};
    end
    if (j < QUO_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_s[j+1] <= ge ? (rem_s[j] - dv) : rem_s[j];
          den_s[j+1] <= den_s[j];
        end
      end
    end
  end

  assign mag_o = q_s[QUO_STEPS];
endmodule
`default_nettype wire

@@ sv/dual_sensor_track_pose.sv @@
// Top level: heading and lateral offset from front and rear line sensors.
//
//  port group   dir  payload
//  s_axis_*     in   sensor counts and offsets (tdata, 72 bits)
//  m_axis_*     out  heading and lateral offset (tdata, 40 bits), pose flag (tuser)
//  cfg_*        in   vehicle_length (16 bits)
//
// Latency is set by the 25-step square root and 19-step divider on the
// lateral path; the CORDIC branch is padded to match.
// One item per cycle sustained while the output is not stalled. Every stage
// advances together; a stalled output register holds all stages and drops s_axis_tready_o.
// Reset clears the valid bits and sets vehicle_length to 1000.
`include "assert_macros.svh"
`default_nettype none
module dual_sensor_track_pose import dstp_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // front_count, front_offset_a, front_offset_b, rear_count, rear_offset_a,
  // rear_offset_b, zero fill
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // heading_angle, lateral_offset, zero fill
  output logic [39:0] m_axis_tdata_o,
  // pose_valid
  output logic        m_axis_tuser_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_data_i
);
  localparam int unsigned VLD_N = 2 + MAG_LAT;

  logic [LEN_W-1:0] len_q;
  logic             adv;
  logic [VLD_N-1:0] vld_q;
  logic             m_tvalid_q;
  logic [39:0]      m_tdata_q;
  logic             m_tuser_q;

  assign cfg_ready_o     = 1'b1;
  assign adv             = !m_tvalid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_valid_i) begin
      len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      m_tvalid_q <= 1'b0;
    end else if (adv) begin
      vld_q      <= {vld_q[VLD_N-2:0], s_axis_tvalid_i};
      m_tvalid_q <= vld_q[VLD_N-1];
    end
  end

  logic [MAG_W-1:0] y, m;
  side_t            side;

  dstp_decode u_decode (
    .clk_i            (clk_i),
    .en_i             (adv),
    .front_count_i    (s_axis_tdata_i[1:0]),
    .front_offset_a_i (s_axis_tdata_i[17:2]),
    .front_offset_b_i (s_axis_tdata_i[33:18]),
    .rear_count_i     (s_axis_tdata_i[35:34]),
    .rear_offset_a_i  (s_axis_tdata_i[51:36]),
    .rear_offset_b_i  (s_axis_tdata_i[67:52]),
    .y_o              (y),
    .m_o              (m),
    .side_o           (side)
  );

  logic [ANG_W-1:0] ang;
  logic [LAT_W-1:0] mag;

  dstp_cordic #(
    .STAGES (CORDIC_STAGES),
    .DEPTH  (MAG_LAT)
  ) u_cordic (
    .clk_i   (clk_i),
    .en_i    (adv),
    .y_i     (y),
    .len_i   (len_q),
    .angle_o (ang)
  );

  dstp_mag u_mag (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (y),
    .m_i   (m),
    .len_i (len_q),
    .mag_o (mag)
  );

  side_t side_q [MAG_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side;
      for (int k = 1; k < MAG_LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  side_t            sd;
  logic [ANG_W-1:0] head_d;
  logic [LAT_W:0]   lat_w;
  logic [LAT_W-1:0] lat_d;

  always_comb begin
    sd     = side_q[MAG_LAT-1];
    head_d = '0;
    lat_d  = '0;
    lat_w  = sd.sd.neg ? ((LAT_W+1)'(0) - {1'b0, mag}) : {1'b0, mag};
    if (sd.pose) begin
      if (sd.sa.nz) head_d = sd.sa.neg ? (ANG_W'(0) - ang) : ang;
      if (sd.spec) begin
        lat_d = sd.spec_lat;
      end else if (sd.sd.nz) begin
        if (!lat_w[LAT_W] && lat_w[LAT_W-1])      lat_d = {1'b0, {(LAT_W-1){1'b1}}};
        else if (lat_w[LAT_W] && !lat_w[LAT_W-1]) lat_d = {1'b1, {(LAT_W-1){1'b0}}};
        else                                      lat_d = lat_w[LAT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_tdata_q <= {5'd0, lat_d, head_d};
      m_tuser_q <= sd.pose;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

  logic signed [ANG_W-1:0] head_o;
  assign head_o = m_tdata_q[ANG_W-1:0];

  `DSTP_ASSERT(a_zero_when_no_pose, m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
  `DSTP_ASSERT(a_heading_range, m_axis_tvalid_o |-> (head_o <= 16'sd25736 && head_o >= -16'sd25736))
  `DSTP_ASSERT(a_stall_backpressure, m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
  `DSTP_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o)
endmodule
`default_nettype wire
